[hdl/cbxd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbxd_pkg - shared types and constants
// Controller/datapath command and status structs, FSM states, register map.
// ----------------------------------------------------------------------------
package cbxd_pkg;

    localparam int unsigned DATA_W   = 16;
    localparam int unsigned CFG_W    = 5;
    localparam int unsigned SQ_W     = 35;

    // register indexes
    localparam logic [1:0] REG_BLOCK_LENGTH  = 2'd0;
    localparam logic [1:0] REG_STAGE_COUNT   = 2'd1;
    localparam logic [1:0] REG_ENVELOPE_MODE = 2'd2;
    localparam logic [1:0] REG_SIGMA_ENABLE  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV,
        ST_VAR,
        ST_ROOT,
        ST_EMIT_MIN,
        ST_EMIT_MAX,
        ST_EMIT_MEAN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load_in;      // capture input beat
        logic write_stage;  // write updated stage at stage index
        logic clear_stage;  // write cleared stage
        logic sq_acc;       // accumulate squares
        logic sq_clear;     // clear square sums
        logic div_start;    // start mean divide
        logic var_start;    // start variance/root
        logic next_stage;   // advance stage index, carry mean as new sample
        logic out_min;      // load output with min pair
        logic out_max;      // load output with max pair
        logic out_mean;     // load output with mean
        logic out_last;     // run_last flag for this beat
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;         // stage reached block length
        logic final_stage;  // stage index is last in use
        logic div_done;
        logic var_done;
        logic env_differs;  // max pair differs from min pair
        logic out_busy;     // output register holds untaken beat
    } t_sts;

endpackage

[hdl/cbxd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbxd_in_if / cbxd_out_if - valid/ready channels
// Sample input channel and point output channel.
// ----------------------------------------------------------------------------
interface cbxd_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    modport source (output valid, sample_x, sample_y, input ready);
    modport sink   (input valid, sample_x, sample_y, output ready);
endinterface

interface cbxd_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic        [15:0] point_sigma;
    logic               run_last;
    modport source (output valid, point_x, point_y, point_sigma, run_last, input ready);
    modport sink   (input valid, point_x, point_y, point_sigma, run_last, output ready);
endinterface

[hdl/cbxd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbxd_datapath - stage memory, accumulators, divider and square root
// Stage records live in a memory; a serial divider forms the floored means,
// a serial multiply/divide/root forms sigma.
// ----------------------------------------------------------------------------
module cbxd_datapath #(
    parameter int unsigned MAX_STAGES = 16,
    parameter int unsigned MAX_BLOCK  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbxd_pkg::t_cmd     i_cmd,
    output cbxd_pkg::t_sts     o_sts,
    input  logic signed [15:0] i_sample_x,
    input  logic signed [15:0] i_sample_y,
    input  logic [4:0]         i_block_length,
    input  logic [4:0]         i_stage_count,
    input  logic               i_sigma_enable,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [15:0] o_point_x,
    output logic signed [15:0] o_point_y,
    output logic [15:0]        o_point_sigma,
    output logic               o_run_last
);
    localparam int unsigned SW   = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int unsigned FW   = $clog2(MAX_BLOCK + 1);
    localparam int unsigned SUMW = 16 + FW;
    localparam int unsigned SQW  = 32 + FW;
    localparam int unsigned NUMW = SQW + FW + 1;  // n*sq, and sum of two
    localparam int unsigned DIVW = SUMW;

    typedef struct packed {
        logic [FW-1:0]         fill;
        logic signed [SUMW-1:0] sx;
        logic signed [SUMW-1:0] sy;
        logic signed [15:0]    mnx;
        logic signed [15:0]    mxx;
        logic signed [15:0]    mny;
        logic signed [15:0]    mxy;
    } t_rec;

    // stage memory with valid bits (reset value zero)
    t_rec                  r_mem [MAX_STAGES];
    logic [MAX_STAGES-1:0] r_vld;
    t_rec                  r_rd;
    logic                  r_rd_vld;
    logic [SW-1:0]         r_idx;

    // effective config
    logic [FW-1:0] w_len;
    logic [SW:0]   w_cnt;
    always_comb begin
        if (i_block_length < 5'd2) w_len = FW'(2);
        else if (32'(i_block_length) > MAX_BLOCK) w_len = FW'(MAX_BLOCK);
        else w_len = FW'(i_block_length);
        if (i_stage_count == 5'd0) w_cnt = (SW+1)'(1);
        else if (32'(i_stage_count) > MAX_STAGES) w_cnt = (SW+1)'(MAX_STAGES);
        else w_cnt = (SW+1)'(i_stage_count);
    end

    // current sample
    logic signed [15:0] r_x, r_y;
    t_rec r_cur;
    t_rec w_rec, w_upd;
    always_comb begin
        w_rec = r_rd_vld ? r_rd : '0;
        w_upd = w_rec;
        if (w_rec.fill == '0) begin
            w_upd.mnx = r_x; w_upd.mxx = r_x; w_upd.mny = r_y; w_upd.mxy = r_y;
        end
        w_upd.sx = w_rec.sx + SUMW'(r_x);
        w_upd.sy = w_rec.sy + SUMW'(r_y);
        if (r_x < w_upd.mnx) w_upd.mnx = r_x;
        if (r_x > w_upd.mxx) w_upd.mxx = r_x;
        if (r_y < w_upd.mny) w_upd.mny = r_y;
        if (r_y > w_upd.mxy) w_upd.mxy = r_y;
        w_upd.fill = w_rec.fill + FW'(1);
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_idx];
        if (i_cmd.write_stage) r_mem[r_idx] <= w_upd;
        if (i_cmd.write_stage) r_cur <= w_upd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_rd_vld <= r_vld[r_idx];
            if (i_cmd.clear_stage) r_vld[r_idx] <= 1'b0;
            else if (i_cmd.write_stage) r_vld[r_idx] <= 1'b1;
            if (i_cmd.load_in) r_idx <= '0;
            else if (i_cmd.next_stage) r_idx <= r_idx + SW'(1);
        end
    end

    // sample register: input beat or carried mean
    logic signed [DIVW-1:0] r_qx, r_qy;
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= i_sample_x; r_y <= i_sample_y;
        end else if (i_cmd.next_stage) begin
            r_x <= r_qx[15:0]; r_y <= r_qy[15:0];
        end
    end

    // sums of squares at final stage
    logic [SQW-1:0] r_sqx, r_sqy;
    logic [15:0] w_ax, w_ay;
    assign w_ax = r_x[15] ? 16'(-r_x) : 16'(r_x);
    assign w_ay = r_y[15] ? 16'(-r_y) : 16'(r_y);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqx <= '0; r_sqy <= '0;
        end else if (i_cmd.sq_clear) begin
            r_sqx <= '0; r_sqy <= '0;
        end else if (i_cmd.sq_acc) begin
            r_sqx <= r_sqx + SQW'(32'(w_ax) * 32'(w_ax));
            r_sqy <= r_sqy + SQW'(32'(w_ay) * 32'(w_ay));
        end
    end

    // floored mean: restoring divide of |sum| by n, both coordinates
    logic [DIVW-1:0] r_rx, r_ry, r_nx, r_ny;
    logic [DIVW-1:0] r_remx, r_remy;
    logic [FW-1:0]   r_n;
    logic [$clog2(DIVW+1)-1:0] r_dcnt;
    logic            r_dbusy, r_ddone;
    logic [DIVW:0]   w_tx, w_ty;
    assign w_tx = {r_remx, r_nx[DIVW-1]};
    assign w_ty = {r_remy, r_ny[DIVW-1]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0; r_ddone <= 1'b0; r_dcnt <= '0;
        end else begin
            r_ddone <= 1'b0;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= '0;
            end else if (r_dbusy) begin
                r_dcnt <= r_dcnt + 1'b1;
                if (32'(r_dcnt) == DIVW - 1) begin
                    r_dbusy <= 1'b0; r_ddone <= 1'b1;
                end
            end
        end
    end
    // operands come from the record being written this cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_n    <= w_upd.fill;
            r_nx   <= w_upd.sx[SUMW-1] ? DIVW'(-w_upd.sx) : DIVW'(w_upd.sx);
            r_ny   <= w_upd.sy[SUMW-1] ? DIVW'(-w_upd.sy) : DIVW'(w_upd.sy);
            r_remx <= '0; r_remy <= '0; r_rx <= '0; r_ry <= '0;
        end else if (r_dbusy) begin
            r_nx <= r_nx << 1; r_ny <= r_ny << 1;
            if (w_tx >= (DIVW+1)'(r_n)) begin
                r_remx <= DIVW'(w_tx - (DIVW+1)'(r_n)); r_rx <= {r_rx[DIVW-2:0], 1'b1};
            end else begin
                r_remx <= DIVW'(w_tx); r_rx <= {r_rx[DIVW-2:0], 1'b0};
            end
            if (w_ty >= (DIVW+1)'(r_n)) begin
                r_remy <= DIVW'(w_ty - (DIVW+1)'(r_n)); r_ry <= {r_ry[DIVW-2:0], 1'b1};
            end else begin
                r_remy <= DIVW'(w_ty); r_ry <= {r_ry[DIVW-2:0], 1'b0};
            end
        end
    end
    // apply sign and floor
    always_comb begin
        r_qx = r_cur.sx[SUMW-1] ? -$signed(r_rx + DIVW'(r_remx != '0)) : $signed(r_rx);
        r_qy = r_cur.sy[SUMW-1] ? -$signed(r_ry + DIVW'(r_remy != '0)) : $signed(r_ry);
    end

    // sigma: numerators, divide by n^2, root; one step per cycle
    typedef enum logic [2:0] {V_IDLE, V_MX, V_MY, V_DIV, V_ROOT, V_DONE} t_vstate;
    t_vstate r_vs;
    logic [NUMW-1:0] r_num, r_t, r_vq, r_vrem;
    logic [2*FW-1:0] r_nn;
    logic [SUMW-1:0] r_mag;
    logic [$clog2(NUMW+1)-1:0] r_vcnt;
    logic [NUMW-1:0] r_rv, r_rr, r_rb;
    logic [15:0]     r_sig;
    logic [NUMW:0]   w_vt;
    logic [NUMW-1:0] w_a, w_b, w_sub;
    assign w_vt = {r_vrem, r_vq[NUMW-1]};
    always_comb begin
        w_a = NUMW'(r_n) * NUMW'(r_vs == V_MX ? r_sqx : r_sqy);
        w_b = NUMW'(r_mag) * NUMW'(r_mag);
        w_sub = (w_a > w_b) ? w_a - w_b : '0;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= V_IDLE;
        end else begin
            case (r_vs)
                V_IDLE: if (i_cmd.var_start) r_vs <= V_MX;
                V_MX:   r_vs <= V_MY;
                V_MY:   r_vs <= V_DIV;
                V_DIV:  if (32'(r_vcnt) == NUMW - 1) r_vs <= V_ROOT;
                V_ROOT: if (r_rb == '0) r_vs <= V_DONE;
                V_DONE: r_vs <= V_IDLE;
                default: r_vs <= V_IDLE;
            endcase
        end
    end
    always_ff @(posedge i_clk) begin
        case (r_vs)
            V_IDLE: begin
                r_mag <= r_cur.sx[SUMW-1] ? SUMW'(-r_cur.sx) : SUMW'(r_cur.sx);
                r_nn  <= (2*FW)'(r_cur.fill) * (2*FW)'(r_cur.fill);
                r_num <= '0;
            end
            V_MX: begin
                r_num <= w_sub;
                r_mag <= r_cur.sy[SUMW-1] ? SUMW'(-r_cur.sy) : SUMW'(r_cur.sy);
            end
            V_MY: begin
                r_vq <= r_num + w_sub; r_vrem <= '0; r_vcnt <= '0; r_t <= '0;
            end
            V_DIV: begin
                r_vcnt <= r_vcnt + 1'b1;
                r_vq   <= {r_vq[NUMW-2:0], 1'b0};
                if (w_vt >= (NUMW+1)'(r_nn)) begin
                    r_vrem <= NUMW'(w_vt - (NUMW+1)'(r_nn)); r_t <= {r_t[NUMW-2:0], 1'b1};
                end else begin
                    r_vrem <= NUMW'(w_vt); r_t <= {r_t[NUMW-2:0], 1'b0};
                end
                if (32'(r_vcnt) == NUMW - 1) begin
                    r_rv <= (w_vt >= (NUMW+1)'(r_nn)) ? {r_t[NUMW-2:0], 1'b1}
                                                      : {r_t[NUMW-2:0], 1'b0};
                    r_rr <= '0;
                    r_rb <= NUMW'(1) << (2 * ((NUMW - 1) / 2));
                end
            end
            V_ROOT: begin
                // root bits run out: hold the result
                if (r_rb != '0) begin
                    if (r_rv >= r_rr + r_rb) begin
                        r_rv <= r_rv - (r_rr + r_rb);
                        r_rr <= (r_rr >> 1) + r_rb;
                    end else begin
                        r_rr <= r_rr >> 1;
                    end
                    r_rb <= r_rb >> 2;
                end
            end
            V_DONE: r_sig <= r_rr[15:0];
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_min || i_cmd.out_max || i_cmd.out_mean) o_out_valid <= 1'b1;
            else if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_min) begin
            o_point_x <= r_cur.mnx; o_point_y <= r_cur.mny; o_point_sigma <= '0;
        end else if (i_cmd.out_max) begin
            o_point_x <= r_cur.mxx; o_point_y <= r_cur.mxy; o_point_sigma <= '0;
        end else if (i_cmd.out_mean) begin
            o_point_x <= r_qx[15:0]; o_point_y <= r_qy[15:0];
            o_point_sigma <= i_sigma_enable ? r_sig : '0;
        end
        if (i_cmd.out_min || i_cmd.out_max || i_cmd.out_mean) o_run_last <= i_cmd.out_last;
    end

    always_comb begin
        o_sts.full        = (w_upd.fill >= w_len);
        o_sts.final_stage = ((SW+1)'(r_idx) == w_cnt - (SW+1)'(1));
        o_sts.div_done    = r_ddone;
        o_sts.var_done    = (r_vs == V_DONE);
        o_sts.env_differs = (r_cur.mxx != r_cur.mnx) || (r_cur.mxy != r_cur.mny);
        o_sts.out_busy    = o_out_valid && !i_out_ready;
    end
endmodule

[hdl/cbxd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbxd_ctrl - sequencer
// Walks one beat through the stages: read, update, divide and carry, sigma, emit.
// ----------------------------------------------------------------------------
module cbxd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_envelope_mode,
    input  logic           i_sigma_enable,
    input  cbxd_pkg::t_sts i_sts,
    output cbxd_pkg::t_cmd o_cmd
);
    cbxd_pkg::t_state r_state, n_state;
    logic r_fin, n_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbxd_pkg::ST_IDLE;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_fin      = r_fin;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            cbxd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = cbxd_pkg::ST_READ;
                end
            end
            // memory read latency
            cbxd_pkg::ST_READ: n_state = cbxd_pkg::ST_UPDATE;
            cbxd_pkg::ST_UPDATE: begin
                o_cmd.write_stage = 1'b1;
                n_fin = i_sts.final_stage;
                if (i_sts.final_stage && i_sigma_enable) o_cmd.sq_acc = 1'b1;
                if (!i_sts.full) begin
                    n_state = cbxd_pkg::ST_IDLE;
                end else begin
                    o_cmd.clear_stage = 1'b1;
                    o_cmd.div_start   = 1'b1;
                    n_state = cbxd_pkg::ST_DIV;
                end
            end
            cbxd_pkg::ST_DIV: begin
                if (i_sts.div_done) begin
                    if (!r_fin) begin
                        o_cmd.next_stage = 1'b1;
                        n_state = cbxd_pkg::ST_READ;
                    end else if (i_envelope_mode) begin
                        n_state = cbxd_pkg::ST_EMIT_MIN;
                    end else if (i_sigma_enable) begin
                        o_cmd.var_start = 1'b1;
                        n_state = cbxd_pkg::ST_VAR;
                    end else begin
                        n_state = cbxd_pkg::ST_EMIT_MEAN;
                    end
                end
            end
            cbxd_pkg::ST_VAR: if (i_sts.var_done) n_state = cbxd_pkg::ST_ROOT;
            cbxd_pkg::ST_ROOT: n_state = cbxd_pkg::ST_EMIT_MEAN;
            cbxd_pkg::ST_EMIT_MEAN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_mean = 1'b1;
                    o_cmd.out_last = 1'b1;
                    o_cmd.sq_clear = 1'b1;
                    n_state = cbxd_pkg::ST_IDLE;
                end
            end
            cbxd_pkg::ST_EMIT_MIN: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_min  = 1'b1;
                    o_cmd.out_last = !i_sts.env_differs;
                    o_cmd.sq_clear = 1'b1;
                    n_state = i_sts.env_differs ? cbxd_pkg::ST_EMIT_MAX : cbxd_pkg::ST_IDLE;
                end
            end
            cbxd_pkg::ST_EMIT_MAX: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_max  = 1'b1;
                    o_cmd.out_last = 1'b1;
                    n_state = cbxd_pkg::ST_IDLE;
                end
            end
            default: n_state = cbxd_pkg::ST_IDLE;
        endcase
    end
endmodule

[hdl/cascaded_boxcar_xy_decimator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cascaded_boxcar_xy_decimator - cascaded box-car X/Y decimator
// A beat that stays in stage 0 passes the read and update states; each stage
// flush adds the serial mean divider and the next stage read/update, and a
// sigma adds the serial divide and root. One beat at a time: a new beat is
// taken only in the idle state, after the stage memory read/update loop and
// any flush and emit. Reset (sync, active low) clears all stages.
// ----------------------------------------------------------------------------
module cascaded_boxcar_xy_decimator #(
    parameter int unsigned MAX_STAGES = 16,
    parameter int unsigned MAX_BLOCK  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbxd_in_if.sink     s_in,
    cbxd_out_if.source  m_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [4:0] r_block_length, r_stage_count;
    logic       r_envelope_mode, r_sigma_enable;
    logic [1:0] w_reg;

    cbxd_pkg::t_cmd w_cmd;
    cbxd_pkg::t_sts w_sts;

    assign pready = 1'b1;
    assign w_reg  = paddr[3:2];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length  <= 5'd2;
            r_stage_count   <= 5'd1;
            r_envelope_mode <= 1'b0;
            r_sigma_enable  <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (w_reg)
                cbxd_pkg::REG_BLOCK_LENGTH:  r_block_length  <= pwdata[4:0];
                cbxd_pkg::REG_STAGE_COUNT:   r_stage_count   <= pwdata[4:0];
                cbxd_pkg::REG_ENVELOPE_MODE: r_envelope_mode <= pwdata[0];
                cbxd_pkg::REG_SIGMA_ENABLE:  r_sigma_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            cbxd_pkg::REG_BLOCK_LENGTH:  prdata = {27'd0, r_block_length};
            cbxd_pkg::REG_STAGE_COUNT:   prdata = {27'd0, r_stage_count};
            cbxd_pkg::REG_ENVELOPE_MODE: prdata = {31'd0, r_envelope_mode};
            cbxd_pkg::REG_SIGMA_ENABLE:  prdata = {31'd0, r_sigma_enable};
            default:                     prdata = '0;
        endcase
    end

    cbxd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_in.valid),
        .o_in_ready      (s_in.ready),
        .i_envelope_mode (r_envelope_mode),
        .i_sigma_enable  (r_sigma_enable),
        .i_sts           (w_sts),
        .o_cmd           (w_cmd)
    );

    cbxd_datapath #(
        .MAX_STAGES (MAX_STAGES),
        .MAX_BLOCK  (MAX_BLOCK)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample_x     (s_in.sample_x),
        .i_sample_y     (s_in.sample_y),
        .i_block_length (r_block_length),
        .i_stage_count  (r_stage_count),
        .i_sigma_enable (r_sigma_enable),
        .i_out_ready    (m_out.ready),
        .o_out_valid    (m_out.valid),
        .o_point_x      (m_out.point_x),
        .o_point_y      (m_out.point_y),
        .o_point_sigma  (m_out.point_sigma),
        .o_run_last     (m_out.run_last)
    );
endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - cascaded box-car X/Y decimator testbench
// Drives sample beats with random gaps, applies several register settings
// between phases, predicts each point in a scoreboard and checks it field by
// field against the point beats taken from the block.
// ----------------------------------------------------------------------------

// Expected point beat
typedef struct {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic        [15:0] sig;
    logic               last;
} t_point;

// Scoreboard: own copy of the stage chain and the expected point queue
class point_scoreboard;
    int unsigned blk_len = 2;
    int unsigned stg_cnt = 1;
    bit          env_mode = 0;
    bit          sig_en = 0;
    int unsigned fill[16];
    longint      sum_x[16], sum_y[16];
    longint      min_x[16], max_x[16], min_y[16], max_y[16];
    longint unsigned sq_x, sq_y;
    t_point      pending[$];
    int          errors = 0;

    function void clear(int s);
        fill[s] = 0; sum_x[s] = 0; sum_y[s] = 0;
        min_x[s] = 0; max_x[s] = 0; min_y[s] = 0; max_y[s] = 0;
    endfunction

    function void reset_all();
        blk_len = 2; stg_cnt = 1; env_mode = 0; sig_en = 0;
        for (int s = 0; s < 16; s++) clear(s);
        sq_x = 0; sq_y = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            cbxd_pkg::REG_BLOCK_LENGTH:  blk_len = val[4:0];
            cbxd_pkg::REG_STAGE_COUNT:   stg_cnt = val[4:0];
            cbxd_pkg::REG_ENVELOPE_MODE: env_mode = val[0];
            cbxd_pkg::REG_SIGMA_ENABLE:  sig_en = val[0];
            default: ;
        endcase
    endfunction

    static function longint fdiv(longint a, longint n);
        longint q;
        q = a / n;
        if ((a % n) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    static function longint unsigned root(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    static function longint unsigned spread(longint unsigned n, longint unsigned sq, longint sm);
        longint unsigned a, m;
        a = n * sq;
        m = sm < 0 ? -sm : sm;
        return a > m * m ? a - m * m : 0;
    endfunction

    function void push(longint x, longint y, longint unsigned sg);
        t_point p;
        p.px = x[15:0]; p.py = y[15:0]; p.sig = sg[15:0]; p.last = 0;
        pending.insert(pending.size(), p);
    endfunction

    // note one accepted sample beat
    function void note_sample(logic signed [15:0] ix, logic signed [15:0] iy);
        int unsigned len, cnt;
        longint x, y, n;
        longint unsigned sg;
        bit fin;
        len = blk_len < 2 ? 2 : (blk_len > 16 ? 16 : blk_len);
        cnt = stg_cnt < 1 ? 1 : (stg_cnt > 16 ? 16 : stg_cnt);
        x = ix; y = iy;
        for (int s = 0; s < cnt; s++) begin
            fin = (s == cnt - 1);
            if (fill[s] == 0) begin
                min_x[s] = x; max_x[s] = x; min_y[s] = y; max_y[s] = y;
            end
            sum_x[s] += x; sum_y[s] += y;
            if (x < min_x[s]) min_x[s] = x;
            if (x > max_x[s]) max_x[s] = x;
            if (y < min_y[s]) min_y[s] = y;
            if (y > max_y[s]) max_y[s] = y;
            if (fin && sig_en) begin
                sq_x += (x < 0 ? -x : x) * (x < 0 ? -x : x);
                sq_y += (y < 0 ? -y : y) * (y < 0 ? -y : y);
            end
            fill[s]++;
            if (fill[s] < len) return;
            n = fill[s];
            if (!fin) begin
                x = fdiv(sum_x[s], n);
                y = fdiv(sum_y[s], n);
                clear(s);
                continue;
            end
            if (env_mode) begin
                push(min_x[s], min_y[s], 0);
                if (max_x[s] != min_x[s] || max_y[s] != min_y[s])
                    push(max_x[s], max_y[s], 0);
            end else begin
                sg = 0;
                if (sig_en)
                    sg = root((spread(n, sq_x, sum_x[s]) + spread(n, sq_y, sum_y[s]))
                              / (n * n));
                push(fdiv(sum_x[s], n), fdiv(sum_y[s], n), sg);
            end
            pending[$].last = 1;
            clear(s);
            sq_x = 0; sq_y = 0;
            return;
        end
    endfunction

    // check one accepted point beat
    function void check_point(logic signed [15:0] px, logic signed [15:0] py,
                              logic [15:0] sig, logic last);
        t_point e;
        if (pending.size() == 0) begin
            $error("unexpected point beat x=%0d y=%0d", px, py);
            errors++;
            return;
        end
        e = pending[0];
        pending.delete(0);
        if (px !== e.px) begin
            $error("point_x expected %0d actual %0d", e.px, px); errors++;
        end
        if (py !== e.py) begin
            $error("point_y expected %0d actual %0d", e.py, py); errors++;
        end
        if (sig !== e.sig) begin
            $error("point_sigma expected %0d actual %0d", e.sig, sig); errors++;
        end
        if (last !== e.last) begin
            $error("run_last expected %0d actual %0d", e.last, last); errors++;
        end
    endfunction
endclass

module tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cbxd_in_if  s_in ();
    cbxd_out_if m_out ();

    point_scoreboard sb = new();
    bit long_hold = 0;
    bit rx_done = 0;

    cascaded_boxcar_xy_decimator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in.sink),
        .m_out   (m_out.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        s_in.valid = 1'b0;
        s_in.sample_x = '0;
        s_in.sample_y = '0;
        m_out.ready = 1'b0;
    end

    // gap length: mostly short, sometimes long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // register write: setup phase, then access phase
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // one sample beat, valid kept high if the next follows directly
    task automatic send_sample(logic signed [15:0] x, logic signed [15:0] y);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_in.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.sample_x <= x;
        s_in.sample_y <= y;
        do @(posedge i_clk); while (!s_in.ready);
        sb.note_sample(x, y);
    endtask

    task automatic end_burst();
        s_in.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait until all points are in, then let the block settle
    task automatic drain();
        int guard;
        guard = 0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (600) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_val();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic random_phase(int n, bit hold);
        for (int i = 0; i < n; i++) begin
            if (hold && i == n / 2) long_hold = 1;
            send_sample(rand_val(), rand_val());
        end
        end_burst();
        drain();
    endtask

    // output side: checks taken point beats; random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        if (i_rst_n && m_out.valid && m_out.ready)
            sb.check_point(m_out.point_x, m_out.point_y, m_out.point_sigma,
                           m_out.run_last);
    end

    initial begin
        int g;
        @(posedge i_rst_n);
        while (!rx_done) begin
            if (long_hold) begin
                m_out.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end
            g = gap_len();
            if (g > 0) begin
                m_out.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            m_out.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sb.reset_all();
        @(posedge i_clk);

        // directed: extremes with reset settings, then envelope and sigma
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(-16'sd3, 16'sd0);
        send_sample(16'sd0, -16'sd2);
        end_burst();
        drain();
        reg_write(cbxd_pkg::REG_ENVELOPE_MODE, 32'd1);
        send_sample(16'sd5, 16'sd5);
        send_sample(16'sd5, 16'sd5);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh7fff, 16'sh8000);
        end_burst();
        drain();
        reg_write(cbxd_pkg::REG_ENVELOPE_MODE, 32'd0);
        reg_write(cbxd_pkg::REG_SIGMA_ENABLE, 32'd1);
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd3);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sd1, 16'sd2);
        end_burst();
        drain();
        // block length below range, stage count zero, then toggle sigma mid-block
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd0);
        reg_write(cbxd_pkg::REG_STAGE_COUNT, 32'd0);
        send_sample(16'sd7, -16'sd7);
        end_burst();
        drain();
        reg_write(cbxd_pkg::REG_SIGMA_ENABLE, 32'd0);
        send_sample(16'sd9, 16'sd1);
        end_burst();
        drain();
        reg_write(cbxd_pkg::REG_SIGMA_ENABLE, 32'd1);

        // random phases over several settings, extremes included
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd2);
        reg_write(cbxd_pkg::REG_STAGE_COUNT, 32'd2);
        random_phase(200, 1);
        reg_write(cbxd_pkg::REG_ENVELOPE_MODE, 32'd1);
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd4);
        reg_write(cbxd_pkg::REG_STAGE_COUNT, 32'd1);
        random_phase(160, 0);
        // larger lengths, then a smaller one with stored contents: stages flush on next pair
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd16);
        random_phase(70, 0);
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd31);
        reg_write(cbxd_pkg::REG_ENVELOPE_MODE, 32'd0);
        random_phase(50, 0);
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd2);
        reg_write(cbxd_pkg::REG_STAGE_COUNT, 32'd31);
        random_phase(120, 0);
        reg_write(cbxd_pkg::REG_STAGE_COUNT, 32'd3);
        reg_write(cbxd_pkg::REG_SIGMA_ENABLE, 32'd0);
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd3);
        random_phase(160, 1);
        reg_write(cbxd_pkg::REG_ENVELOPE_MODE, 32'd1);
        reg_write(cbxd_pkg::REG_BLOCK_LENGTH, 32'd2);
        reg_write(cbxd_pkg::REG_STAGE_COUNT, 32'd1);
        random_phase(60, 0);

        rx_done = 1;
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (sb.pending.size() != 0)
                $error("%0d points never arrived", sb.pending.size());
            $display("Regression FAIL");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
